### hdl/ggdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggdc_pkg
// Shared types, constants and microcode for the go-to-goal drive controller.
// ----------------------------------------------------------------------------
package ggdc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_IW          = 5;   // index width of the arctangent table
  localparam int PC_W             = 3;

  // input operation codes
  localparam logic [1:0] OPN_TICK  = 2'd0;
  localparam logic [1:0] OPN_START = 2'd1;
  localparam logic [1:0] OPN_STOP  = 2'd2;

  localparam longint    PI_Q30       = 64'd3373259426;
  localparam int        PI_Q13       = 25736;
  localparam int        INV_GAIN_Q16 = 39797;
  localparam int        RECIP5_Q18   = 52429;  // ceil(2^18 / 5)
  localparam int        TURN_MAX     = 3277;
  localparam int        DRV_TURN_MAX = 2048;
  localparam int        SPEED_MIN    = 819;
  localparam int        SPEED_MAX    = 3277;
  localparam int        SPEED_SAT_D  = 409;    // above this, 8*dist passes SPEED_MAX

  typedef enum logic [2:0] {
    OP_IDLE, OP_ROTATE, OP_MUL_LO, OP_MUL_HI, OP_DIST, OP_DECIDE, OP_FINISH, OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    J_NEXT, J_DISPATCH, J_LOOP, J_WAIT_OUT
  } jmp_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_t  op;
    jmp_t jmp;
    pc_t  target;
  } ucode_t;

  typedef struct packed {
    logic go;
    logic stop;
    logic out_free;
  } cond_t;

  localparam pc_t PC_IDLE   = 3'd0;
  localparam pc_t PC_ROTATE = 3'd1;
  localparam pc_t PC_MUL_LO = 3'd2;
  localparam pc_t PC_MUL_HI = 3'd3;
  localparam pc_t PC_DIST   = 3'd4;
  localparam pc_t PC_DECIDE = 3'd5;
  localparam pc_t PC_FINISH = 3'd6;
  localparam pc_t PC_EMIT   = 3'd7;

  function automatic ucode_t ucode(input pc_t pc);
    ucode_t w;
    unique case (pc)
      PC_IDLE:   w = '{op: OP_IDLE,   jmp: J_DISPATCH, target: PC_EMIT};
      PC_ROTATE: w = '{op: OP_ROTATE, jmp: J_LOOP,     target: PC_ROTATE};
      PC_MUL_LO: w = '{op: OP_MUL_LO, jmp: J_NEXT,     target: PC_IDLE};
      PC_MUL_HI: w = '{op: OP_MUL_HI, jmp: J_NEXT,     target: PC_IDLE};
      PC_DIST:   w = '{op: OP_DIST,   jmp: J_NEXT,     target: PC_IDLE};
      PC_DECIDE: w = '{op: OP_DECIDE, jmp: J_NEXT,     target: PC_IDLE};
      PC_FINISH: w = '{op: OP_FINISH, jmp: J_NEXT,     target: PC_IDLE};
      PC_EMIT:   w = '{op: OP_EMIT,   jmp: J_WAIT_OUT, target: PC_IDLE};
      default:   w = '{op: OP_IDLE,   jmp: J_NEXT,     target: PC_IDLE};
    endcase
    return w;
  endfunction

  // arctangent of 2^-i, Q.30 radians
  function automatic logic [29:0] atan_q30(input logic [ATAN_IW-1:0] idx);
    logic [29:0] a;
    case (idx)
      5'd0:    a = 30'd843314857;
      5'd1:    a = 30'd497837829;
      5'd2:    a = 30'd263043837;
      5'd3:    a = 30'd133525159;
      5'd4:    a = 30'd67021687;
      5'd5:    a = 30'd33543516;
      5'd6:    a = 30'd16775851;
      5'd7:    a = 30'd8388437;
      5'd8:    a = 30'd4194283;
      5'd9:    a = 30'd2097149;
      5'd10:   a = 30'd1048576;
      5'd11:   a = 30'd524288;
      5'd12:   a = 30'd262144;
      5'd13:   a = 30'd131072;
      5'd14:   a = 30'd65536;
      5'd15:   a = 30'd32768;
      5'd16:   a = 30'd16384;
      5'd17:   a = 30'd8192;
      5'd18:   a = 30'd4096;
      5'd19:   a = 30'd2048;
      5'd20:   a = 30'd1024;
      5'd21:   a = 30'd512;
      5'd22:   a = 30'd256;
      5'd23:   a = 30'd128;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

### hdl/ggdc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggdc_seq
// Microcode sequencer: program counter, control ROM, CORDIC iteration count.
// ----------------------------------------------------------------------------
module ggdc_seq #(
  parameter int CORDIC_STEPS = ggdc_pkg::CORDIC_STEPS_DEF,
  localparam int IW = $clog2(CORDIC_STEPS)
) (
  input  logic              clk,
  input  logic              rst,
  input  ggdc_pkg::cond_t   cond,
  output ggdc_pkg::ucode_t  ctrl,
  output logic [IW-1:0]     iter
);

  ggdc_pkg::pc_t pc, pc_next;
  logic [IW-1:0] iter_next;
  logic          last;

  assign ctrl = ggdc_pkg::ucode(pc);
  assign last = (iter == IW'(CORDIC_STEPS - 1));

  always_comb begin
    unique case (ctrl.jmp)
      ggdc_pkg::J_NEXT:     pc_next = pc + 1'b1;
      ggdc_pkg::J_DISPATCH: pc_next = cond.go ? pc + 1'b1 : (cond.stop ? ctrl.target : pc);
      ggdc_pkg::J_LOOP:     pc_next = last ? pc + 1'b1 : ctrl.target;
      ggdc_pkg::J_WAIT_OUT: pc_next = cond.out_free ? ctrl.target : pc;
      default:              pc_next = pc;
    endcase
    iter_next = (ctrl.op == ggdc_pkg::OP_ROTATE) ? iter + 1'b1 : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= ggdc_pkg::PC_IDLE;
      iter <= '0;
    end else begin
      pc   <= pc_next;
      iter <= iter_next;
    end
  end

endmodule

### hdl/go_to_goal_drive_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_drive_controller_unit
// Flow: a navigating control tick runs the CORDIC rotations, then the multiply,
//   distance, decide, finish and emit states; a stop command goes straight to
//   the emit state and shows a zero beat; start and dropped ticks give no beat.
//   Input is taken only in the idle state, so a tick holds off new input until its
//   result is handed on; the iterative CORDIC and shared 24x16 multiplier set the rate.
// Reset (synchronous, rst high): disarmed, goal flag clear, registers at
//   their defaults, output empty.
// ----------------------------------------------------------------------------
module go_to_goal_drive_controller_unit #(
  parameter int CORDIC_STEPS = ggdc_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // position_east[31:0], position_north[63:32], heading[79:64]
  input  logic [2:0]  s_tuser,   // operation[1:0], sensors_ready[2]
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // forward_speed[11:0], turn_rate[24:12], zero pad
  output logic [0:0]  m_tuser    // arrived[0]
);

  localparam int IW = $clog2(CORDIC_STEPS);
  localparam int XW = 48;   // 33-bit delta, 12 guard bits, CORDIC growth
  localparam int ZW = 35;   // Q.30 angle with headroom
  localparam int BW = ZW - 17;
  localparam int EW = 19;
  localparam int DW = 36;

  localparam logic [1:0] REG_GOAL_EAST  = 2'd0;
  localparam logic [1:0] REG_GOAL_NORTH = 2'd1;
  localparam logic [1:0] REG_ARRIVE     = 2'd2;
  localparam logic [1:0] REG_HEAD_TOL   = 2'd3;

  localparam logic signed [ZW-1:0] PI_Z   = ZW'(ggdc_pkg::PI_Q30);
  localparam logic signed [EW-1:0] PI_E   = EW'(ggdc_pkg::PI_Q13);
  localparam logic signed [EW-1:0] TWO_PI = EW'(2 * ggdc_pkg::PI_Q13);

  // configuration registers
  logic signed [31:0] goal_east, goal_north;
  logic [15:0]        arrive_radius;
  logic [14:0]        heading_tolerance;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_east         <= '0;
      goal_north        <= '0;
      arrive_radius     <= 16'd128;
      heading_tolerance <= 15'd1229;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_GOAL_EAST:  goal_east         <= pwdata;
        REG_GOAL_NORTH: goal_north        <= pwdata;
        REG_ARRIVE:     arrive_radius     <= pwdata[15:0];
        REG_HEAD_TOL:   heading_tolerance <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GOAL_EAST:  prdata = goal_east;
      REG_GOAL_NORTH: prdata = goal_north;
      REG_ARRIVE:     prdata = {16'b0, arrive_radius};
      REG_HEAD_TOL:   prdata = {17'b0, heading_tolerance};
      default:        prdata = '0;
    endcase
  end

  // sequencer
  ggdc_pkg::ucode_t ctrl;
  ggdc_pkg::cond_t  cond;
  logic [IW-1:0]    iter;

  ggdc_seq #(.CORDIC_STEPS(CORDIC_STEPS)) u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .ctrl (ctrl),
    .iter (iter)
  );

  logic armed, goal_done;
  logic in_acc, out_free;
  logic [1:0] in_op;

  assign s_tready = (ctrl.op == ggdc_pkg::OP_IDLE);
  assign in_acc   = s_tvalid & s_tready;
  assign in_op    = s_tuser[1:0];
  assign out_free = ~m_tvalid | m_tready;

  assign cond.go       = in_acc & (in_op == ggdc_pkg::OPN_TICK) & armed & ~goal_done
                       & s_tuser[2];
  assign cond.stop     = in_acc & (in_op == ggdc_pkg::OPN_STOP);
  assign cond.out_free = out_free;

  // datapath
  logic signed [XW-1:0] x, y, xsh, ysh, x0, y0;
  logic signed [ZW-1:0] z, zr, at;
  logic signed [32:0]   dx, dy;
  logic signed [15:0]   heading_r;
  logic signed [BW-1:0] bearing;
  logic signed [EW-1:0] err_raw, err_wrap, err;
  logic [23:0]          mul_a;
  logic [39:0]          mul_p;
  logic [63:0]          acc, dsum;
  logic [DW-1:0]        distance;
  logic [EW-1:0]        mag;
  logic                 neg, reach, spin;
  logic [16:0]          div_in;
  logic [32:0]          prod5;
  logic [20:0]          spin_t;
  logic [14:0]          fwd_q;
  logic [11:0]          turn_mag, speed_v, d8;
  logic [11:0]          res_speed;
  logic [12:0]          res_turn;
  logic                 res_arrived;
  logic [11:0]          out_speed;
  logic [12:0]          out_turn;
  logic                 out_arrived;

  assign dx  = {goal_east[31], goal_east} - {s_tdata[31], s_tdata[31:0]};
  assign dy  = {goal_north[31], goal_north} - {s_tdata[63], s_tdata[63:32]};
  assign x0  = {{(XW - 45){dx[32]}}, dx, 12'b0};
  assign y0  = {{(XW - 45){dy[32]}}, dy, 12'b0};

  assign xsh = x >>> iter;
  assign ysh = y >>> iter;
  assign at  = ZW'({1'b0, ggdc_pkg::atan_q30(ggdc_pkg::ATAN_IW'(iter))});

  // x is non-negative after the CORDIC: split it for the 24x16 multiplier
  assign mul_a = (ctrl.op == ggdc_pkg::OP_MUL_HI) ? {1'b0, x[46:24]} : x[23:0];
  assign mul_p = 40'(mul_a) * 40'(ggdc_pkg::INV_GAIN_Q16);
  assign dsum  = acc + (64'd1 << 27);

  assign zr      = z + ZW'(1 << 16);
  assign bearing = BW'(zr >>> 17);
  assign err_raw = EW'(bearing) - EW'(heading_r);

  always_comb begin
    if (err_raw > PI_E)
      err_wrap = err_raw - TWO_PI;
    else if (err_raw < -PI_E)
      err_wrap = err_raw + TWO_PI;
    else
      err_wrap = err_raw;
  end

  // forward turn (2*mag + 2) / 5; only used while mag <= heading_tolerance
  assign div_in = {mag[15:0], 1'b0} + 17'd2;
  assign spin_t = ({2'b0, mag} + {1'b0, mag, 1'b0} + 21'd2) >> 2;
  assign fwd_q  = prod5[32:18];
  assign d8     = {distance[8:0], 3'b0};

  always_comb begin
    if (spin) begin
      turn_mag = (spin_t > 21'(ggdc_pkg::TURN_MAX)) ? 12'(ggdc_pkg::TURN_MAX) : spin_t[11:0];
      speed_v  = '0;
    end else begin
      turn_mag = (fwd_q > 15'(ggdc_pkg::DRV_TURN_MAX)) ? 12'(ggdc_pkg::DRV_TURN_MAX)
                                                        : fwd_q[11:0];
      if (distance > DW'(ggdc_pkg::SPEED_SAT_D))
        speed_v = 12'(ggdc_pkg::SPEED_MAX);
      else if (d8 < 12'(ggdc_pkg::SPEED_MIN))
        speed_v = 12'(ggdc_pkg::SPEED_MIN);
      else
        speed_v = d8;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      ggdc_pkg::OP_IDLE: begin
        heading_r <= s_tdata[79:64];
        if (dx[32]) begin
          x <= -x0;
          y <= -y0;
          z <= dy[32] ? -PI_Z : PI_Z;
        end else begin
          x <= x0;
          y <= y0;
          z <= '0;
        end
        res_speed   <= '0;
        res_turn    <= '0;
        res_arrived <= 1'b0;
      end
      ggdc_pkg::OP_ROTATE: begin
        if (!y[XW-1]) begin
          x <= x + ysh;
          y <= y - xsh;
          z <= z + at;
        end else begin
          x <= x - ysh;
          y <= y + xsh;
          z <= z - at;
        end
      end
      ggdc_pkg::OP_MUL_LO: begin
        acc <= 64'(mul_p);
        err <= err_wrap;
      end
      ggdc_pkg::OP_MUL_HI: acc <= acc + {mul_p, 24'b0};
      ggdc_pkg::OP_DIST: begin
        distance <= dsum[63:28];
        mag      <= err[EW-1] ? EW'(-err) : EW'(err);
        neg      <= err[EW-1];
      end
      ggdc_pkg::OP_DECIDE: begin
        reach <= distance < DW'(arrive_radius);
        spin  <= mag > EW'(heading_tolerance);
        prod5 <= 33'(div_in) * 33'(ggdc_pkg::RECIP5_Q18);
      end
      ggdc_pkg::OP_FINISH: begin
        if (reach) begin
          res_speed   <= '0;
          res_turn    <= '0;
          res_arrived <= 1'b1;
        end else begin
          res_speed   <= speed_v;
          res_turn    <= neg ? -{1'b0, turn_mag} : {1'b0, turn_mag};
          res_arrived <= 1'b0;
        end
      end
      ggdc_pkg::OP_EMIT: begin
        if (out_free) begin
          out_speed   <= res_speed;
          out_turn    <= res_turn;
          out_arrived <= res_arrived;
        end
      end
      default: ;
    endcase
  end

  // navigation state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b0;
      goal_done <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (in_acc && in_op == ggdc_pkg::OPN_START) begin
        armed     <= 1'b1;
        goal_done <= 1'b0;
      end else if (cond.stop) begin
        armed     <= 1'b0;
        goal_done <= 1'b0;
      end else if (ctrl.op == ggdc_pkg::OP_FINISH && reach) begin
        armed     <= 1'b0;
        goal_done <= 1'b1;
      end
      if (ctrl.op == ggdc_pkg::OP_EMIT && out_free)
        m_tvalid <= 1'b1;
      else if (m_tready)
        m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {7'b0, out_turn, out_speed};
  assign m_tuser = out_arrived;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for go_to_goal_drive_controller_unit. Command beats are
// queued by the stimulus block. A stream driver feeds them with random gaps.
// A scoreboard predicts each steering beat from a bit-exact model of the
// CORDIC range/bearing math and the steering rules. The sink compares every
// result beat, field by field. Goal and tolerance registers go over APB
// between phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] OPN_SPARE = 2'd3;   // unused opcode, must be ignored

  localparam int REG_GOAL_EAST  = 0;
  localparam int REG_GOAL_NORTH = 1;
  localparam int REG_ARRIVE     = 2;
  localparam int REG_HEAD_TOL   = 3;

  localparam int GUARD       = 12;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 40;
  localparam int PHASE_ITEMS = 84;
  localparam int LONG_STALL  = 400;

  localparam longint ARCTAN_Q30 [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] pos_e;
    logic signed [31:0] pos_n;
    logic signed [15:0] hdg;
    logic               rdy;
  } nav_cmd_t;

  typedef struct {
    logic [11:0]        speed;
    logic signed [12:0] turn;
    logic               arrived;
  } steer_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;   // position_east[31:0], position_north[63:32], heading[79:64]
  logic [2:0]  s_tuser = '0;   // operation[1:0], sensors_ready[2]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // forward_speed[11:0], turn_rate[24:12], zero pad
  logic [0:0]  m_tuser;        // arrived[0]

  // register mirror and controller state
  logic signed [31:0] goal_e = '0;
  logic signed [31:0] goal_n = '0;
  logic [15:0]        arrive_r = 16'd128;
  logic [14:0]        head_tol = 15'd1229;
  bit                 nav_armed = 1'b0;
  bit                 nav_at_goal = 1'b0;

  nav_cmd_t   nav_cmds[$];
  steer_cmd_t steer_due[$];
  nav_cmd_t   cmd_on_bus;
  steer_cmd_t next_due;

  int cmds_pushed = 0;
  int cmds_taken = 0;
  int work_items = 0;
  int bad_beats = 0;
  int cycle_cnt = 0;
  int src_odds = 0;
  int sink_odds = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int stall_asks = 0;
  int stall_seen = 0;
  int stall_left = 0;

  go_to_goal_drive_controller_unit uut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL go_to_goal_drive_controller_unit");
      $finish;
    end
  end

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Steering command for one accepted beat; returns 1 when a beat is due.
  function automatic bit steer_predict(input nav_cmd_t c, output steer_cmd_t r);
    longint x, y, z, xs, ys, distance, bearing, herr, mag, turn, speed;
    r = '{speed: '0, turn: '0, arrived: 1'b0};
    if (c.op == ggdc_pkg::OPN_START) begin
      nav_armed = 1'b1;
      nav_at_goal = 1'b0;
      return 1'b0;
    end
    if (c.op == ggdc_pkg::OPN_STOP) begin
      nav_armed = 1'b0;
      nav_at_goal = 1'b0;
      return 1'b1;
    end
    if (c.op != ggdc_pkg::OPN_TICK || !nav_armed || nav_at_goal || !c.rdy) return 1'b0;

    x = (longint'(goal_e) - longint'(c.pos_e)) * (64'sd1 <<< GUARD);
    y = (longint'(goal_n) - longint'(c.pos_n)) * (64'sd1 <<< GUARD);
    z = 0;
    // pre-rotate by pi so vectoring starts in the right half plane
    if (x < 0) begin
      z = (y >= 0) ? ggdc_pkg::PI_Q30 : -ggdc_pkg::PI_Q30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ggdc_pkg::CORDIC_STEPS_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_Q30[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_Q30[i];
      end
    end
    distance = (x * ggdc_pkg::INV_GAIN_Q16 + (64'sd1 <<< (15 + GUARD))) >>> (16 + GUARD);
    bearing = (z + 64'sd65536) >>> 17;

    herr = bearing - longint'(c.hdg);
    if (herr > ggdc_pkg::PI_Q13) herr = herr - 2 * ggdc_pkg::PI_Q13;
    else if (herr < -ggdc_pkg::PI_Q13) herr = herr + 2 * ggdc_pkg::PI_Q13;

    if (distance < longint'(arrive_r)) begin
      nav_armed = 1'b0;
      nav_at_goal = 1'b1;
      r.arrived = 1'b1;
      return 1'b1;
    end

    mag = (herr < 0) ? -herr : herr;
    if (mag > longint'(head_tol)) begin
      turn = (3 * mag + 2) >>> 2;
      if (herr < 0) turn = -turn;
      turn = sat(turn, -ggdc_pkg::TURN_MAX, ggdc_pkg::TURN_MAX);
      speed = 0;
    end else begin
      turn = (2 * mag + 2) / 5;
      if (herr < 0) turn = -turn;
      turn = sat(turn, -ggdc_pkg::DRV_TURN_MAX, ggdc_pkg::DRV_TURN_MAX);
      speed = sat(distance * 8, ggdc_pkg::SPEED_MIN, ggdc_pkg::SPEED_MAX);
    end
    r.speed = speed[11:0];
    r.turn = turn[12:0];
    return 1'b1;
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (steer_predict(cmd_on_bus, next_due)) steer_due.push_back(next_due);
        cmds_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (src_odds != 0 && $urandom_range(1, src_odds) == 1) begin
          src_gap = $urandom_range(0, 12);
          s_tvalid <= 1'b0;
        end else if (nav_cmds.size() != 0) begin
          cmd_on_bus = nav_cmds.pop_front();
          s_tdata <= {cmd_on_bus.hdg, cmd_on_bus.pos_n, cmd_on_bus.pos_e};
          s_tuser <= {cmd_on_bus.rdy, cmd_on_bus.op};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink and checker
  always @(posedge clk) begin
    steer_cmd_t exp_beat;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (steer_due.size() == 0) begin
          $error("unexpected result beat: speed %0d turn %0d arrived %0d",
                 m_tdata[11:0], $signed(m_tdata[24:12]), m_tuser[0]);
          bad_beats++;
        end else begin
          exp_beat = steer_due.pop_front();
          if (m_tdata[11:0] !== exp_beat.speed) begin
            $error("forward_speed mismatch: expected %0d, actual %0d",
                   exp_beat.speed, m_tdata[11:0]);
            bad_beats++;
          end
          if (m_tdata[24:12] !== exp_beat.turn) begin
            $error("turn_rate mismatch: expected %0d, actual %0d",
                   exp_beat.turn, $signed(m_tdata[24:12]));
            bad_beats++;
          end
          if (m_tuser[0] !== exp_beat.arrived) begin
            $error("arrived mismatch: expected %0d, actual %0d",
                   exp_beat.arrived, m_tuser[0]);
            bad_beats++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (stall_asks != stall_seen) begin
        stall_seen = stall_asks;
        stall_left = LONG_STALL;
        m_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if (sink_odds != 0 && $urandom_range(1, sink_odds) == 1) begin
        sink_gap = $urandom_range(0, 12);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic reg_write(input int idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GOAL_EAST:  goal_e = val;
      REG_GOAL_NORTH: goal_n = val;
      REG_ARRIVE:     arrive_r = val[15:0];
      REG_HEAD_TOL:   head_tol = val[14:0];
      default: ;
    endcase
  endtask

  task automatic set_goal(input logic [31:0] ge, input logic [31:0] gn,
                          input logic [15:0] ar, input logic [14:0] ht);
    reg_write(REG_GOAL_EAST, ge);
    reg_write(REG_GOAL_NORTH, gn);
    reg_write(REG_ARRIVE, {16'd0, ar});
    reg_write(REG_HEAD_TOL, {17'd0, ht});
  endtask

  task automatic push_cmd(input logic [1:0] op, input logic signed [31:0] pe,
                          input logic signed [31:0] pn, input logic signed [15:0] hdg,
                          input logic rdy);
    nav_cmd_t c;
    c = '{op: op, pos_e: pe, pos_n: pn, hdg: hdg, rdy: rdy};
    nav_cmds.push_back(c);
    cmds_pushed++;
    if (op != OPN_SPARE && !(op == ggdc_pkg::OPN_TICK && !rdy)) work_items++;
  endtask

  // wait until every command is in and every steering beat is out
  task automatic settle();
    while (cmds_taken != cmds_pushed || steer_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_pos(input logic signed [31:0] goal);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return goal + ($urandom_range(0, 1200) - 600);
      2: return goal + ($urandom_range(0, 1 << 21) - (1 << 20));
      3: return goal + ($urandom_range(0, 1 << 13) - (1 << 12));
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0;
          default: return goal;
        endcase
      end
      default: return goal + ($urandom_range(0, 400) - 200);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_heading();
    case ($urandom_range(0, 7))
      0: return 16'($urandom);       // anywhere, including past +-pi
      1: return ($urandom_range(0, 1) != 0) ? 16'(ggdc_pkg::PI_Q13) : 16'(-ggdc_pkg::PI_Q13);
      default: return 16'($urandom_range(0, 2 * ggdc_pkg::PI_Q13) - ggdc_pkg::PI_Q13);
    endcase
  endfunction

  // heading roughly toward the goal so the drive-forward branch gets exercised
  function automatic logic signed [15:0] aim_heading(input logic signed [31:0] pe,
                                                     input logic signed [31:0] pn);
    real ang;
    ang = $atan2(real'(longint'(goal_n) - longint'(pn)),
                 real'(longint'(goal_e) - longint'(pe)));
    return 16'(int'(ang * 8192.0) + int'($urandom_range(0, 2 * head_tol + 64))
               - int'(head_tol) - 32);
  endfunction

  // one navigation run: start, a few ticks, maybe a stop, with some noise
  task automatic add_trip();
    int legs, sel;
    logic signed [31:0] pe, pn;
    logic signed [15:0] hdg;
    logic [1:0] op;
    if ($urandom_range(0, 9) != 0)
      push_cmd(ggdc_pkg::OPN_START, $urandom, $urandom, 16'($urandom), 1'($urandom));
    legs = $urandom_range(1, 10);
    repeat (legs) begin
      pe = rand_pos(goal_e);
      pn = rand_pos(goal_n);
      hdg = ($urandom_range(0, 1) != 0) ? aim_heading(pe, pn) : rand_heading();
      sel = $urandom_range(0, 24);
      case (sel)
        0: op = OPN_SPARE;
        1: op = ggdc_pkg::OPN_START;
        2: op = ggdc_pkg::OPN_STOP;
        default: op = ggdc_pkg::OPN_TICK;
      endcase
      push_cmd(op, pe, pn, hdg, (sel == 3) ? 1'b0 : 1'b1);
    end
    if ($urandom_range(0, 2) == 0)
      push_cmd(ggdc_pkg::OPN_STOP, $urandom, $urandom, 16'($urandom), 1'($urandom));
  endtask

  initial begin
    int target;
    logic [31:0] ge, gn;
    logic [15:0] ar;
    logic [14:0] ht;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    src_odds = 4;
    sink_odds = 4;

    // directed pass at reset defaults: goal at origin
    push_cmd(ggdc_pkg::OPN_TICK, 32'sd256000, 0, 0, 1'b1);          // disarmed tick
    push_cmd(OPN_SPARE, 32'sd5, 32'sd7, 16'sd9, 1'b1);
    push_cmd(ggdc_pkg::OPN_STOP, 0, 0, 0, 1'b0);
    push_cmd(ggdc_pkg::OPN_START, 0, 0, 0, 1'b0);
    push_cmd(ggdc_pkg::OPN_TICK, -32'sd25600, 0, 0, 1'b0);          // sensors not ready
    push_cmd(ggdc_pkg::OPN_TICK, 0, 0, 0, 1'b1);                    // sitting on the goal
    push_cmd(ggdc_pkg::OPN_TICK, -32'sd25600, 0, 0, 1'b1);          // already done
    push_cmd(ggdc_pkg::OPN_START, 0, 0, 0, 1'b1);
    push_cmd(ggdc_pkg::OPN_TICK, -32'sd25600, 0, 0, 1'b1);          // speed saturates
    push_cmd(ggdc_pkg::OPN_TICK, -32'sd200, 0, 0, 1'b1);            // mid-range speed
    push_cmd(ggdc_pkg::OPN_TICK, -32'sd25600, 0, 16'sd25736, 1'b1); // turn rate clamps
    push_cmd(ggdc_pkg::OPN_TICK, -32'sd25600, 0, 16'sd2000, 1'b1);  // turn in place
    push_cmd(ggdc_pkg::OPN_TICK, -32'sd25600, 0, -16'sd1000, 1'b1); // drive with correction
    push_cmd(ggdc_pkg::OPN_TICK, 32'sd25600, 0, 16'sd25736, 1'b1);  // goal behind, dy zero
    push_cmd(ggdc_pkg::OPN_TICK, 32'sd25600, 32'sd256, -16'sd25736, 1'b1); // goal behind, dy < 0
    push_cmd(ggdc_pkg::OPN_TICK, 32'sd25600, -32'sd256, 16'sh8000, 1'b1);  // heading past -pi
    push_cmd(ggdc_pkg::OPN_TICK, 32'h8000_0000, 32'h8000_0000, 16'sd32767, 1'b1);
    push_cmd(ggdc_pkg::OPN_TICK, 32'h7fff_ffff, 32'h7fff_ffff, 0, 1'b1);
    push_cmd(ggdc_pkg::OPN_TICK, 0, -32'sd25600, 16'sd12868, 1'b1);  // heading north
    push_cmd(ggdc_pkg::OPN_STOP, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 1'b1);
    push_cmd(ggdc_pkg::OPN_TICK, 0, 0, 0, 1'b1);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          ge = 32'h8000_0000; gn = 32'h8000_0000; ar = 16'd0; ht = 15'd0;
        end
        1: begin
          ge = 32'h7fff_ffff; gn = 32'h7fff_ffff; ar = 16'hffff; ht = 15'(ggdc_pkg::PI_Q13);
        end
        default: begin
          if ($urandom_range(0, 2) == 0) begin
            ge = $urandom;
            gn = $urandom;
          end else begin
            ge = $urandom_range(0, 1 << 20) - (1 << 19);
            gn = $urandom_range(0, 1 << 20) - (1 << 19);
          end
          case ($urandom_range(0, 3))
            0: ar = 16'($urandom_range(0, 100));
            1: ar = 16'($urandom);
            default: ar = 16'($urandom_range(0, 2000));
          endcase
          ht = ($urandom_range(0, 3) == 0) ? 15'd1229
                                           : 15'($urandom_range(0, ggdc_pkg::PI_Q13));
        end
      endcase
      set_goal(ge, gn, ar, ht);
      if (phase == 7) begin
        src_odds = 0;
        sink_odds = 0;
      end else begin
        src_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 8);
        sink_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 8);
      end
      // long sink hold-off while commands keep coming: backs up the input
      if (phase == 3) stall_asks++;
      target = work_items + PHASE_ITEMS;
      while (work_items < target) add_trip();
      settle();
    end

    if (bad_beats == 0 && steer_due.size() == 0) begin
      $display("PASS go_to_goal_drive_controller_unit");
    end else begin
      $display("FAIL go_to_goal_drive_controller_unit");
    end
    $finish;
  end

endmodule
